// File: hw/rtl/sentence_framed_char_ring_buffer_core_macros.svh
// Assertion helpers shared by the ring buffer RTL.
`ifndef SENTENCE_FRAMED_CHAR_RING_BUFFER_CORE_MACROS_SVH
`define SENTENCE_FRAMED_CHAR_RING_BUFFER_CORE_MACROS_SVH

// Plain property, clocked on clk_i, off while reset is asserted
`define SFCRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication
`define SFCRB_ASSERT_IMP(lbl, ante, cons, msg) \
  `SFCRB_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define SFCRB_ASSERT_NXT(lbl, ante, cons, msg) \
  `SFCRB_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: hw/rtl/sfcrb_pkg.sv
package sfcrb_pkg;

  // Default store depth in characters
  localparam int unsigned BUFFER_DEPTH_DEF = 256;

  // Sentence start character '$'
  localparam logic [7:0] START_MARK = 8'h24;

  typedef enum logic [2:0] {
    OP_ADD_CHAR     = 3'd0,
    OP_DELETE       = 3'd1,
    OP_READ_FIRST   = 3'd2,
    OP_READ_CURRENT = 3'd3,
    OP_READ_NEXT    = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       sentence_ready;
    logic       store_empty;
    logic       store_full;
  } out_word_t;

endpackage

// File: hw/rtl/sentence_framed_char_ring_buffer_core.sv
// Flow: an accepted word passes through ST_RESP, which loads the registered result
// word; a delete first scans in ST_SCAN, one store read per cycle.
// The input takes one word at a time for every opcode and stalls
// while a word is in work or its result waits for the output register.
// Reset: asynchronous, active low; afterwards the store is zeroed one entry a
// cycle, with the input stalled until it completes.
`include "sentence_framed_char_ring_buffer_core_macros.svh"

module sentence_framed_char_ring_buffer_core #(
  parameter int unsigned BUFFER_DEPTH = sfcrb_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfcrb_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfcrb_pkg::out_word_t out_word_o
);

  localparam int unsigned PtrW = $clog2(BUFFER_DEPTH);
  localparam logic [PtrW-1:0] Last = PtrW'(BUFFER_DEPTH - 1);

  // Wrapping pointer increment
  function automatic logic [PtrW-1:0] adv(input logic [PtrW-1:0] p);
    return (p == Last) ? '0 : p + PtrW'(1);
  endfunction

  sfcrb_pkg::state_e state_q, state_d;
  sfcrb_pkg::op_e    op_q, op_d;

  logic [PtrW-1:0] start_q, start_d;
  logic [PtrW-1:0] wp_q, wp_d;
  logic [PtrW-1:0] ce_q, ce_d;
  logic [PtrW-1:0] cursor_q, cursor_d;
  logic [PtrW-1:0] scan_q, scan_d;
  logic [PtrW-1:0] clr_q, clr_d;
  logic            ovf_q, ovf_d;
  logic            await_q, await_d;

  logic            out_valid_q, out_valid_d;
  sfcrb_pkg::out_word_t out_q, out_d;

  // Store port
  logic [7:0]      mem [BUFFER_DEPTH];
  logic            mem_we, mem_re;
  logic [PtrW-1:0] mem_addr;
  logic [7:0]      mem_wdata;
  logic [7:0]      rdata_q;

  logic            accept, out_free;
  logic [PtrW-1:0] wp_adv, st_adv, cur_adv, scan_adv;
  logic            has_sentence, del_scan, scan_done;

  assign accept       = in_valid_i && (state_q == sfcrb_pkg::ST_IDLE);
  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != sfcrb_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_q;

  assign wp_adv       = adv(wp_q);
  assign st_adv       = adv(start_q);
  assign cur_adv      = adv(cursor_q);
  assign scan_adv     = adv(scan_q);
  assign has_sentence = (start_q != ce_q);
  assign del_scan     = has_sentence && (st_adv != ce_q);
  assign scan_done    = (rdata_q == sfcrb_pkg::START_MARK) || (scan_adv == ce_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfcrb_pkg::ST_CLEAR: begin
        if (clr_q == Last) state_d = sfcrb_pkg::ST_IDLE;
      end
      sfcrb_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_word_i.opcode == sfcrb_pkg::OP_DELETE) && del_scan) begin
            state_d = sfcrb_pkg::ST_SCAN;
          end else begin
            state_d = sfcrb_pkg::ST_RESP;
          end
        end
      end
      sfcrb_pkg::ST_SCAN: begin
        if (scan_done) state_d = sfcrb_pkg::ST_RESP;
      end
      sfcrb_pkg::ST_RESP: begin
        if (out_free) state_d = sfcrb_pkg::ST_IDLE;
      end
    endcase
  end

  // Pointer updates and store access
  always_comb begin
    start_d   = start_q;
    wp_d      = wp_q;
    ce_d      = ce_q;
    cursor_d  = cursor_q;
    scan_d    = scan_q;
    clr_d     = clr_q;
    ovf_d     = ovf_q;
    await_d   = await_q;
    op_d      = op_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wp_q;
    mem_wdata = in_word_i.char_in;
    unique case (state_q)
      sfcrb_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = adv(clr_q);
      end
      sfcrb_pkg::ST_IDLE: begin
        if (accept) begin
          op_d = sfcrb_pkg::op_e'(in_word_i.opcode);
          unique case (sfcrb_pkg::op_e'(in_word_i.opcode))
            sfcrb_pkg::OP_ADD_CHAR: begin
              if (!ovf_q && (!await_q || (in_word_i.char_in == sfcrb_pkg::START_MARK))) begin
                if (wp_adv == start_q) begin
                  // store full: drop the partial sentence
                  ovf_d   = 1'b1;
                  await_d = 1'b1;
                  wp_d    = ce_q;
                end else begin
                  if (in_word_i.char_in == sfcrb_pkg::START_MARK) ce_d = wp_q;
                  mem_we  = 1'b1;
                  wp_d    = wp_adv;
                  await_d = 1'b0;
                end
              end
            end
            sfcrb_pkg::OP_DELETE: begin
              if (has_sentence) begin
                if (del_scan) begin
                  mem_re   = 1'b1;
                  mem_addr = st_adv;
                  scan_d   = st_adv;
                end else begin
                  start_d = st_adv;
                  ovf_d   = 1'b0;
                end
              end
            end
            sfcrb_pkg::OP_READ_FIRST: begin
              cursor_d = start_q;
              mem_re   = 1'b1;
              mem_addr = start_q;
            end
            sfcrb_pkg::OP_READ_CURRENT: begin
              mem_re   = 1'b1;
              mem_addr = cursor_q;
            end
            sfcrb_pkg::OP_READ_NEXT: begin
              cursor_d = cur_adv;
              mem_re   = 1'b1;
              mem_addr = cur_adv;
            end
            default: begin
            end
          endcase
        end
      end
      sfcrb_pkg::ST_SCAN: begin
        // rdata_q holds the character at scan_q
        if (rdata_q == sfcrb_pkg::START_MARK) begin
          start_d = scan_q;
          ovf_d   = 1'b0;
        end else if (scan_adv == ce_q) begin
          start_d = scan_adv;
          ovf_d   = 1'b0;
        end else begin
          mem_re   = 1'b1;
          mem_addr = scan_adv;
          scan_d   = scan_adv;
        end
      end
      sfcrb_pkg::ST_RESP: begin
      end
    endcase
  end

  // Result word
  always_comb begin
    out_d                = out_q;
    out_valid_d          = out_valid_q && out_stall_i;
    if ((state_q == sfcrb_pkg::ST_RESP) && out_free) begin
      out_valid_d          = 1'b1;
      out_d.char_out       = '0;
      out_d.char_valid     = 1'b0;
      unique case (op_q)
        sfcrb_pkg::OP_READ_FIRST,
        sfcrb_pkg::OP_READ_NEXT: begin
          out_d.char_out   = rdata_q;
          out_d.char_valid = 1'b1;
        end
        sfcrb_pkg::OP_READ_CURRENT: begin
          if (has_sentence) begin
            out_d.char_out   = rdata_q;
            out_d.char_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      out_d.sentence_ready = has_sentence;
      out_d.store_empty    = (start_q == wp_q);
      out_d.store_full     = ovf_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfcrb_pkg::ST_CLEAR;
      start_q     <= '0;
      wp_q        <= '0;
      ce_q        <= '0;
      cursor_q    <= '0;
      clr_q       <= '0;
      ovf_q       <= 1'b0;
      await_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      wp_q        <= wp_d;
      ce_q        <= ce_d;
      cursor_q    <= cursor_d;
      clr_q       <= clr_d;
      ovf_q       <= ovf_d;
      await_q     <= await_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    scan_q <= scan_d;
    out_q  <= out_d;
  end

  // Character store, one port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  `SFCRB_ASSERT_IMP(a_result_from_resp, $rose(out_valid_q), $past(state_q == sfcrb_pkg::ST_RESP),
                    "result word loaded outside the response state")
  `SFCRB_ASSERT(a_ptr_range, (wp_q <= Last) && (start_q <= Last) && (ce_q <= Last),
                "pointer beyond store depth")
  `SFCRB_ASSERT_IMP(a_scan_has_sentence, state_q == sfcrb_pkg::ST_SCAN, scan_q != ce_q,
                    "scan running past the committed end")
  `SFCRB_ASSERT_IMP(a_ovf_awaits, ovf_q, await_q, "overflow without waiting for a start mark")
  `SFCRB_ASSERT_NXT(a_one_at_a_time, accept, in_stall_o, "second word taken while one is in work")

endmodule

// File: dv/ring_store_checker.sv
module ring_store_checker
  import sfcrb_pkg::*;
#(
  parameter int unsigned DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned full_seen_o,
  output int unsigned valid_reads_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // Shadow copy of the character store and its pointers
  logic [7:0]  chars_q [DEPTH];
  int unsigned head_q;    // oldest sentence start
  int unsigned tail_q;    // next write slot
  int unsigned commit_q;  // end of committed data
  int unsigned cursor_q;  // read cursor
  logic        full_q;
  logic        hunting_q; // dropping input until the next '$'

  out_word_t   status_q[$];
  int unsigned mismatches, checked, full_seen, valid_reads;

  assign mismatches_o  = mismatches;
  assign pending_o     = status_q.size();
  assign checked_o     = checked;
  assign full_seen_o   = full_seen;
  assign valid_reads_o = valid_reads;

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // Apply one input word to the shadow store, return the status it produces
  function automatic out_word_t ring_store_apply(in_word_t w);
    out_word_t   r;
    int unsigned nxt;
    int unsigned p;
    int unsigned steps;
    logic        found;
    r = '0;
    case (w.opcode)
      OP_ADD_CHAR: begin
        if (!full_q && (!hunting_q || w.char_in == START_MARK)) begin
          hunting_q = 1'b0;
          nxt = next_slot(tail_q);
          if (nxt == head_q) begin
            // no room: drop the partial sentence and wait for a fresh '$'
            full_q    = 1'b1;
            hunting_q = 1'b1;
            tail_q    = commit_q;
          end else begin
            if (w.char_in == START_MARK) commit_q = tail_q;
            chars_q[tail_q] = w.char_in;
            tail_q = nxt;
          end
        end
      end
      OP_DELETE: begin
        if (head_q != commit_q) begin
          p = head_q;
          found = 1'b0;
          for (steps = 0; steps < DEPTH && !found; steps++) begin
            p = next_slot(p);
            found = (p == commit_q) || (chars_q[p] == START_MARK);
          end
          head_q = p;
          full_q = 1'b0;
        end
      end
      OP_READ_FIRST: begin
        cursor_q     = head_q;
        r.char_out   = chars_q[cursor_q];
        r.char_valid = 1'b1;
      end
      OP_READ_CURRENT: begin
        if (head_q != commit_q) begin
          r.char_out   = chars_q[cursor_q];
          r.char_valid = 1'b1;
        end
      end
      OP_READ_NEXT: begin
        cursor_q     = next_slot(cursor_q);
        r.char_out   = chars_q[cursor_q];
        r.char_valid = 1'b1;
      end
      default: ;
    endcase
    r.sentence_ready = head_q != commit_q;
    r.store_empty    = head_q == tail_q;
    r.store_full     = full_q;
    return r;
  endfunction

  // Compare each result word with the oldest prediction, then predict new input
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) chars_q[i] = '0;
      head_q    = 0;
      tail_q    = 0;
      commit_q  = 0;
      cursor_q  = 0;
      full_q    = 1'b0;
      hunting_q = 1'b1;
      status_q.delete();
      mismatches  = 0;
      checked     = 0;
      full_seen   = 0;
      valid_reads = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (out_word_i.store_full === 1'b1) full_seen++;
        if (out_word_i.char_valid === 1'b1) valid_reads++;
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with nothing outstanding: char %02h valid %b",
                     checked, out_word_i.char_out, out_word_i.char_valid);
        end else begin
          want = status_q.pop_front();
          if (out_word_i.char_out !== want.char_out ||
              out_word_i.char_valid !== want.char_valid ||
              out_word_i.sentence_ready !== want.sentence_ready ||
              out_word_i.store_empty !== want.store_empty ||
              out_word_i.store_full !== want.store_full) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"result %0d mismatch: expected char %02h valid %b ready %b",
                        " empty %b full %b, got char %02h valid %b ready %b empty %b full %b"},
                       checked, want.char_out, want.char_valid, want.sentence_ready,
                       want.store_empty, want.store_full, out_word_i.char_out,
                       out_word_i.char_valid, out_word_i.sentence_ready,
                       out_word_i.store_empty, out_word_i.store_full);
          end
        end
      end
      if (in_valid_i && !in_stall_i) status_q.push_back(ring_store_apply(in_word_i));
    end
  end

endmodule

// File: dv/tb.sv
module tb;
  import sfcrb_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1950;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [2:0]  OP_CODE_TOP  = 3'd7;  // highest opcode the field holds

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_word_t    in_word   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  out_word_t   out_word;

  logic        calm        = 1'b0;  // no new gaps or stalls begin while set
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned words_sent  = 0;
  int unsigned mismatches, pending, checked, full_seen, valid_reads;

  sentence_framed_char_ring_buffer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  ring_store_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_seen_o   (full_seen),
    .valid_reads_o (valid_reads)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short idle stretches, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Body character: anything but the start mark
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    return (c == START_MARK) ? ~c : c;
  endfunction

  // Receiver back-pressure: hold stall high or low for random stretches
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= !calm && ($urandom_range(99) < 30);
      stall_left <= pick_gap();
    end
  end

  // Watchdog on cycles without any word moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Present one word, optionally after a gap, and wait until it is taken
  task automatic push_word(input logic [2:0] op, input logic [7:0] ch);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{opcode: op, char_in: ch};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic push_sentence(input int unsigned len);
    push_word(OP_ADD_CHAR, START_MARK);
    repeat (len) push_word(OP_ADD_CHAR, body_char());
  endtask

  initial begin
    int unsigned random_base;
    int unsigned r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads on an empty store, spare opcodes, framing, delete
    push_word(OP_READ_CURRENT, 8'h00);
    push_word(OP_READ_FIRST, 8'hFF);
    push_word(OP_READ_NEXT, 8'h00);
    for (int op = int'(OP_READ_NEXT) + 1; op <= int'(OP_CODE_TOP); op++)
      push_word(op[2:0], 8'hA5);
    push_word(OP_DELETE, 8'h00);
    push_word(OP_ADD_CHAR, 8'h41);      // dropped, no '$' seen yet
    push_word(OP_ADD_CHAR, START_MARK);
    push_word(OP_ADD_CHAR, 8'h00);
    push_word(OP_ADD_CHAR, 8'hFF);
    push_word(OP_ADD_CHAR, 8'h41);
    push_word(OP_ADD_CHAR, START_MARK); // commits the first sentence
    push_word(OP_READ_CURRENT, 8'h00);
    push_word(OP_READ_FIRST, 8'h00);
    push_word(OP_READ_NEXT, 8'h00);
    push_word(OP_READ_NEXT, 8'h00);
    push_word(OP_ADD_CHAR, 8'h7F);
    push_word(OP_DELETE, 8'h00);
    push_word(OP_READ_CURRENT, 8'h00);
    push_word(OP_DELETE, 8'h00);        // nothing committed any more
    push_word(OP_ADD_CHAR, START_MARK);
    push_word(OP_DELETE, 8'h00);

    // Random: mostly framed sentences, deletes and read walks, some noise
    random_base = words_sent;
    while (words_sent - random_base < RANDOM_WORDS) begin
      calm <= ($urandom_range(7) == 0);
      r = $urandom_range(99);
      if (r < 40) begin
        push_sentence(($urandom_range(9) == 0) ? $urandom_range(120, 40)
                                               : $urandom_range(15, 0));
      end else if (r < 60) begin
        repeat ($urandom_range(2, 1)) push_word(OP_DELETE, 8'($urandom_range(255)));
      end else if (r < 80) begin
        push_word(OP_READ_FIRST, 8'($urandom_range(255)));
        repeat ($urandom_range(8, 0)) push_word(OP_READ_NEXT, 8'($urandom_range(255)));
        push_word(OP_READ_CURRENT, 8'($urandom_range(255)));
      end else if (r < 90) begin
        repeat ($urandom_range(6, 1))
          push_word(3'($urandom_range(int'(OP_CODE_TOP))), 8'($urandom_range(255)));
      end else if (r < 93) begin
        // long sentence that runs into the start pointer
        push_sentence($urandom_range(300, 256));
      end else begin
        // characters with no leading '$'
        repeat ($urandom_range(5, 1)) push_word(OP_ADD_CHAR, body_char());
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words; %0d results checked, %0d valid reads, %0d with store full",
             words_sent, checked, valid_reads, full_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d failing results", mismatches);
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
